@@ design/ptc_pkg.sv @@
package ptc_pkg;

  typedef logic        [19:0] adc_t;
  typedef logic signed [19:0] fine_t;
  typedef logic signed [14:0] temp_t;
  typedef logic signed [63:0] scaled_t;
  typedef logic signed [35:0] den_t;
  typedef logic signed [37:0] quo_t;
  typedef logic        [31:0] press_t;

  // calibration register indexes, byte address is 8 * index
  typedef enum logic [1:0] {
    REG_TEMP_CALIB = 2'd0,
    REG_PRESS_A    = 2'd1,
    REG_PRESS_B    = 2'd2,
    REG_PRESS_C    = 2'd3
  } reg_idx_t;

  // unpacked calibration words, first word of each register in bits 47:32
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } calib_t;

endpackage

@@ design/ptc_temp.sv @@
module ptc_temp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  ptc_pkg::calib_t cal,
  input  logic            vld_i,
  input  ptc_pkg::adc_t   adc_temp_i,
  input  ptc_pkg::adc_t   adc_press_i,
  output logic            vld_o,
  output ptc_pkg::fine_t  tf_o,
  output ptc_pkg::adc_t   adc_press_o
);

  logic [3:0]          vld_r;
  ptc_pkg::adc_t       press_r [0:3];
  logic signed [17:0]  diff_r, diff_nxt;
  logic signed [16:0]  d_r, d_nxt;
  logic signed [33:0]  m1_r, m1_nxt;
  logic signed [33:0]  dd_r, dd_nxt;
  logic signed [22:0]  a_r, a_nxt;
  logic signed [37:0]  m2_r, m2_nxt;
  logic signed [23:0]  b;
  logic signed [24:0]  sum;
  ptc_pkg::fine_t      tf_r, tf_nxt;

  always_comb begin
    diff_nxt = $signed({1'b0, adc_temp_i[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    d_nxt    = $signed({1'b0, adc_temp_i[19:4]}) - $signed({1'b0, cal.t1});
    m1_nxt   = diff_r * $signed(cal.t2);
    dd_nxt   = d_r * d_r;
    a_nxt    = m1_r[33:11];
    m2_nxt   = $signed(dd_r[33:12]) * $signed(cal.t3);
    b        = m2_r[37:14];
    sum      = {{2{a_r[22]}}, a_r} + {b[23], b};
    if (sum > 25'sd524287) begin
      tf_nxt = 20'sh7FFFF;
    end else if (sum < -25'sd524288) begin
      tf_nxt = 20'sh80000;
    end else begin
      tf_nxt = sum[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r     <= diff_nxt;
      d_r        <= d_nxt;
      m1_r       <= m1_nxt;
      dd_r       <= dd_nxt;
      a_r        <= a_nxt;
      m2_r       <= m2_nxt;
      tf_r       <= tf_nxt;
      press_r[0] <= adc_press_i;
      for (int k = 1; k < 4; k++) begin
        press_r[k] <= press_r[k-1];
      end
    end
  end

  assign vld_o       = vld_r[3];
  assign tf_o        = tf_r;
  assign adc_press_o = press_r[3];

endmodule

@@ design/ptc_coef.sv @@
module ptc_coef (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  ptc_pkg::calib_t  cal,
  input  logic             vld_i,
  input  ptc_pkg::fine_t   tf_i,
  input  ptc_pkg::adc_t    adc_press_i,
  output logic             vld_o,
  output ptc_pkg::scaled_t nx_o,
  output ptc_pkg::den_t    den_o,
  output ptc_pkg::fine_t   tf_o,
  output ptc_pkg::temp_t   tc_o
);

  // largest dividend that survives the multiply by 3125 in 64 bits
  localparam logic signed [57:0] NUM_LIM = 58'sd2951479051793528;

  logic [6:0]          vld_r;
  ptc_pkg::fine_t      tf_r [0:6];
  ptc_pkg::temp_t      tc_r [0:6];
  logic [20:0]         pv_r [0:3];
  logic [20:0]         pv_nxt;
  logic signed [22:0]  tx;
  logic signed [14:0]  tq;
  ptc_pkg::temp_t      tc_nxt;
  logic signed [20:0]  a1_r, a1_nxt;
  logic signed [41:0]  aa_r, aa_nxt;
  logic signed [36:0]  ap5_r, ap5_nxt, ap5d_r;
  logic signed [36:0]  ap2_r, ap2_nxt, ap2d_r;
  logic signed [57:0]  b1_r, b1_nxt;
  logic signed [57:0]  c1_r, c1_nxt;
  logic signed [57:0]  b_r, b_nxt;
  logic signed [51:0]  am_r, am_nxt;
  logic signed [57:0]  nr;
  logic signed [52:0]  num_r, num_nxt;
  logic signed [34:0]  ah_r;
  logic [16:0]         al_r;
  ptc_pkg::scaled_t    nx_r, nx_nxt, nxd_r;
  logic signed [51:0]  mh_r, mh_nxt;
  logic [32:0]         ml_r, ml_nxt;
  logic signed [51:0]  dsum;
  ptc_pkg::den_t       den_r;

  always_comb begin
    a1_nxt = $signed({tf_i[19], tf_i}) - 21'sd128000;
    tx     = {tf_i[19], tf_i, 2'b00} + {{3{tf_i[19]}}, tf_i} + 23'd128;
    tq     = tx[22:8];
    if (tq > 15'sd8500) begin
      tc_nxt = 15'sd8500;
    end else if (tq < -15'sd4000) begin
      tc_nxt = -15'sd4000;
    end else begin
      tc_nxt = tq;
    end
    pv_nxt  = 21'd1048576 - {1'b0, adc_press_i};

    aa_nxt  = a1_r * a1_r;
    ap5_nxt = a1_r * $signed(cal.p5);
    ap2_nxt = a1_r * $signed(cal.p2);

    b1_nxt  = aa_r * $signed(cal.p6);
    c1_nxt  = aa_r * $signed(cal.p3);

    b_nxt   = b1_r + $signed({{4{ap5d_r[36]}}, ap5d_r, 17'b0})
            + $signed({{7{cal.p4[15]}}, cal.p4, 35'b0});
    am_nxt  = $signed({{2{c1_r[57]}}, c1_r[57:8]})
            + $signed({{3{ap2d_r[36]}}, ap2d_r, 12'b0})
            + 52'sh0800000000000;

    nr = $signed({6'b0, pv_r[3], 31'b0}) - b_r;
    if (nr > NUM_LIM) begin
      num_nxt = NUM_LIM[52:0];
    end else if (nr < -NUM_LIM) begin
      num_nxt = 53'(-NUM_LIM);
    end else begin
      num_nxt = nr[52:0];
    end

    // A * P1 >> 33 taken in a high and a low half
    nx_nxt = num_r * 64'sd3125;
    mh_nxt = ah_r * $signed({1'b0, cal.p1});
    ml_nxt = al_r * cal.p1;
    dsum   = mh_r + $signed({36'b0, ml_r[32:17]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= a1_nxt;
      aa_r   <= aa_nxt;
      ap5_r  <= ap5_nxt;
      ap2_r  <= ap2_nxt;
      b1_r   <= b1_nxt;
      c1_r   <= c1_nxt;
      ap5d_r <= ap5_r;
      ap2d_r <= ap2_r;
      b_r    <= b_nxt;
      am_r   <= am_nxt;
      num_r  <= num_nxt;
      ah_r   <= am_r[51:17];
      al_r   <= am_r[16:0];
      nx_r   <= nx_nxt;
      mh_r   <= mh_nxt;
      ml_r   <= ml_nxt;
      nxd_r  <= nx_r;
      den_r  <= dsum[51:16];
      tf_r[0] <= tf_i;
      tc_r[0] <= tc_nxt;
      pv_r[0] <= pv_nxt;
      for (int k = 1; k < 7; k++) begin
        tf_r[k] <= tf_r[k-1];
        tc_r[k] <= tc_r[k-1];
      end
      for (int k = 1; k < 4; k++) begin
        pv_r[k] <= pv_r[k-1];
      end
    end
  end

  assign vld_o = vld_r[6];
  assign nx_o  = nxd_r;
  assign den_o = den_r;
  assign tf_o  = tf_r[6];
  assign tc_o  = tc_r[6];

endmodule

@@ design/ptc_div.sv @@
module ptc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  ptc_pkg::scaled_t nx_i,
  input  ptc_pkg::den_t    den_i,
  input  ptc_pkg::fine_t   tf_i,
  input  ptc_pkg::temp_t   tc_i,
  output logic             vld_o,
  output ptc_pkg::quo_t    q_o,
  output logic             dz_o,
  output ptc_pkg::fine_t   tf_o,
  output ptc_pkg::temp_t   tc_o
);

  // one quotient bit per stage; bits above 36 only flag saturation
  localparam int STEPS = 37;

  typedef struct packed {
    logic           qneg;
    logic           ovf;
    logic           dz;
    ptc_pkg::fine_t tf;
    ptc_pkg::temp_t tc;
  } side_t;

  logic               va_r;
  logic [62:0]        na_r;
  logic [35:0]        da_r;
  side_t              sa_r, sa_nxt, sb_nxt;
  logic [63:0]        nabs;
  logic [35:0]        dabs;

  logic [STEPS:0]     vld_r;
  logic [35:0]        rem_r  [0:STEPS];
  logic [36:0]        low_r  [0:STEPS];
  logic [35:0]        dm_r   [0:STEPS];
  side_t              side_r [0:STEPS];
  logic [36:0]        r2     [0:STEPS-1];
  logic [36:0]        sub    [0:STEPS-1];
  logic [STEPS-1:0]   ge;

  logic [36:0]        qm, qc;
  logic [37:0]        qw;
  logic               vo_r;
  ptc_pkg::quo_t      q_r;
  side_t              so_r;

  always_comb begin
    nabs = nx_i[63] ? (64'd0 - nx_i) : nx_i;
    dabs = den_i[35] ? (36'd0 - den_i) : den_i;
    sa_nxt      = '0;
    sa_nxt.qneg = nx_i[63] ^ den_i[35];
    sa_nxt.dz   = (den_i == '0);
    sa_nxt.tf   = tf_i;
    sa_nxt.tc   = tc_i;

    sb_nxt      = sa_r;
    sb_nxt.ovf  = ({10'b0, na_r[62:37]} >= da_r);

    for (int k = 0; k < STEPS; k++) begin
      r2[k]  = {rem_r[k], low_r[k][36]};
      sub[k] = r2[k] - {1'b0, dm_r[k]};
      ge[k]  = (r2[k] >= {1'b0, dm_r[k]});
    end

    qm = low_r[STEPS];
    if (side_r[STEPS].ovf || (qm > 37'h1000000000)) begin
      qc = 37'h1000000000;
    end else begin
      qc = qm;
    end
    qw = side_r[STEPS].qneg ? (38'd0 - {1'b0, qc}) : {1'b0, qc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vld_r <= '0;
      vo_r  <= 1'b0;
    end else if (en) begin
      va_r  <= vld_i;
      vld_r <= {vld_r[STEPS-1:0], va_r};
      vo_r  <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r      <= nabs[62:0];
      da_r      <= dabs;
      sa_r      <= sa_nxt;
      rem_r[0]  <= {10'b0, na_r[62:37]};
      low_r[0]  <= na_r[36:0];
      dm_r[0]   <= da_r;
      side_r[0] <= sb_nxt;
      for (int k = 0; k < STEPS; k++) begin
        rem_r[k+1]  <= ge[k] ? sub[k][35:0] : r2[k][35:0];
        low_r[k+1]  <= {low_r[k][35:0], ge[k]};
        dm_r[k+1]   <= dm_r[k];
        side_r[k+1] <= side_r[k];
      end
      q_r  <= qw;
      so_r <= side_r[STEPS];
    end
  end

  assign vld_o = vo_r;
  assign q_o   = q_r;
  assign dz_o  = so_r.dz;
  assign tf_o  = so_r.tf;
  assign tc_o  = so_r.tc;

endmodule

@@ design/ptc_post.sv @@
module ptc_post (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  ptc_pkg::calib_t cal,
  input  logic            vld_i,
  input  ptc_pkg::quo_t   q_i,
  input  logic            dz_i,
  input  ptc_pkg::fine_t  tf_i,
  input  ptc_pkg::temp_t  tc_i,
  output logic            vld_o,
  output ptc_pkg::temp_t  tc_o,
  output ptc_pkg::press_t press_o,
  output ptc_pkg::fine_t  tf_o,
  output logic            dz_o
);

  logic [3:0]          vld_r;
  ptc_pkg::quo_t       q_r [0:1];
  logic                dz_r [0:3];
  ptc_pkg::fine_t      tf_r [0:3];
  ptc_pkg::temp_t      tc_r [0:3];
  logic signed [24:0]  ps;
  logic signed [47:0]  sq_r, sq_nxt;
  logic signed [53:0]  m8_r, m8_nxt, m8d_r;
  logic signed [63:0]  m9_r, m9_nxt;
  logic signed [39:0]  s_r, s_nxt;
  logic signed [33:0]  pr;
  ptc_pkg::press_t     press_r, press_nxt;

  always_comb begin
    ps     = q_i[37:13];
    sq_nxt = ps * ps;
    m8_nxt = q_i * $signed(cal.p8);
    m9_nxt = sq_r * $signed(cal.p9);
    s_nxt  = $signed({{2{q_r[1][37]}}, q_r[1]}) + $signed({m9_r[63], m9_r[63:25]})
           + $signed({{5{m8d_r[53]}}, m8d_r[53:19]});
    pr     = $signed({{2{s_r[39]}}, s_r[39:8]})
           + $signed({{14{cal.p7[15]}}, cal.p7, 4'b0});
    if (dz_r[2] || pr < 34'sd0) begin
      press_nxt = '0;
    end else if (pr > 34'sh0FFFFFFFF) begin
      press_nxt = 32'hFFFF_FFFF;
    end else begin
      press_nxt = pr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r    <= sq_nxt;
      m8_r    <= m8_nxt;
      m9_r    <= m9_nxt;
      m8d_r   <= m8_r;
      s_r     <= s_nxt;
      press_r <= press_nxt;
      q_r[0]  <= q_i;
      q_r[1]  <= q_r[0];
      dz_r[0] <= dz_i;
      tf_r[0] <= tf_i;
      tc_r[0] <= tc_i;
      for (int k = 1; k < 4; k++) begin
        dz_r[k] <= dz_r[k-1];
        tf_r[k] <= tf_r[k-1];
        tc_r[k] <= tc_r[k-1];
      end
    end
  end

  assign vld_o   = vld_r[3];
  assign tc_o    = tc_r[3];
  assign press_o = press_r;
  assign tf_o    = tf_r[3];
  assign dz_o    = dz_r[3];

endmodule

@@ design/pressure_temperature_compensation.sv @@
// Barometric sensor compensation pipeline.
// Input channel (in_valid/in_stall): one transaction carries a raw 20-bit
// temperature and a raw 20-bit pressure conversion. Output channel
// (out_valid/out_stall): one transaction per input carrying the temperature
// in 0.01 degC, pressure in Pa as unsigned Q24.8, the fine temperature and
// a flag set when the pressure divisor came out zero (pressure is then 0).
// Calibration sits in four 48-bit registers on the APB port at byte
// addresses 0, 8, 16, 24; write them only while the pipeline is empty.
// Throughput: one transaction per cycle while the output is not stalled.
// The path holds 55 register stages: 4 temperature, 7 pressure coefficient,
// 40 in the divider (37 of them one quotient bit each) and 4 final correction.
// A stalled output freezes every stage at once; in_stall is raised for as
// long as a valid result sits stalled at the output, so nothing is lost.
// Reset clears all stage valid bits and the calibration registers to zero.
module pressure_temperature_compensation (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [19:0]            in_adc_temp,
  input  logic [19:0]            in_adc_press,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [14:0]     out_temp_centi,
  output logic [31:0]            out_press_q24_8,
  output logic signed [19:0]     out_fine_temp,
  output logic                   out_div_zero,
  // APB configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  logic [47:0]        temp_calib_r, press_a_r, press_b_r, press_c_r;
  ptc_pkg::reg_idx_t  idx;
  logic               wr_en;
  ptc_pkg::calib_t    cal;
  logic               en;

  // stage interconnect
  logic             t_vld;
  ptc_pkg::fine_t   t_tf;
  ptc_pkg::adc_t    t_press;
  logic             c_vld;
  ptc_pkg::scaled_t c_nx;
  ptc_pkg::den_t    c_den;
  ptc_pkg::fine_t   c_tf;
  ptc_pkg::temp_t   c_tc;
  logic             d_vld;
  ptc_pkg::quo_t    d_q;
  logic             d_dz;
  ptc_pkg::fine_t   d_tf;
  ptc_pkg::temp_t   d_tc;

  // ---- register file ----
  assign idx    = ptc_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_a_r    <= '0;
      press_b_r    <= '0;
      press_c_r    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ptc_pkg::REG_TEMP_CALIB: temp_calib_r <= pwdata[47:0];
        ptc_pkg::REG_PRESS_A:    press_a_r    <= pwdata[47:0];
        ptc_pkg::REG_PRESS_B:    press_b_r    <= pwdata[47:0];
        ptc_pkg::REG_PRESS_C:    press_c_r    <= pwdata[47:0];
        default:                 temp_calib_r <= temp_calib_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ptc_pkg::REG_TEMP_CALIB: prdata = {16'b0, temp_calib_r};
      ptc_pkg::REG_PRESS_A:    prdata = {16'b0, press_a_r};
      ptc_pkg::REG_PRESS_B:    prdata = {16'b0, press_b_r};
      ptc_pkg::REG_PRESS_C:    prdata = {16'b0, press_c_r};
      default:                 prdata = '0;
    endcase
  end

  // calibration words, first word of each register in the top bits
  always_comb begin
    cal.t1 = temp_calib_r[47:32];
    cal.t2 = temp_calib_r[31:16];
    cal.t3 = temp_calib_r[15:0];
    cal.p1 = press_a_r[47:32];
    cal.p2 = press_a_r[31:16];
    cal.p3 = press_a_r[15:0];
    cal.p4 = press_b_r[47:32];
    cal.p5 = press_b_r[31:16];
    cal.p6 = press_b_r[15:0];
    cal.p7 = press_c_r[47:32];
    cal.p8 = press_c_r[31:16];
    cal.p9 = press_c_r[15:0];
  end

  // ---- pipeline ----
  // global advance: everything moves unless a result is held at the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ptc_temp u_temp (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .cal         (cal),
    .vld_i       (in_valid),
    .adc_temp_i  (in_adc_temp),
    .adc_press_i (in_adc_press),
    .vld_o       (t_vld),
    .tf_o        (t_tf),
    .adc_press_o (t_press)
  );

  ptc_coef u_coef (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .cal         (cal),
    .vld_i       (t_vld),
    .tf_i        (t_tf),
    .adc_press_i (t_press),
    .vld_o       (c_vld),
    .nx_o        (c_nx),
    .den_o       (c_den),
    .tf_o        (c_tf),
    .tc_o        (c_tc)
  );

  ptc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (c_vld),
    .nx_i  (c_nx),
    .den_i (c_den),
    .tf_i  (c_tf),
    .tc_i  (c_tc),
    .vld_o (d_vld),
    .q_o   (d_q),
    .dz_o  (d_dz),
    .tf_o  (d_tf),
    .tc_o  (d_tc)
  );

  // last stage of the correction block is the output register
  ptc_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cal     (cal),
    .vld_i   (d_vld),
    .q_i     (d_q),
    .dz_i    (d_dz),
    .tf_i    (d_tf),
    .tc_i    (d_tc),
    .vld_o   (out_valid),
    .tc_o    (out_temp_centi),
    .press_o (out_press_q24_8),
    .tf_o    (out_fine_temp),
    .dz_o    (out_div_zero)
  );

endmodule

@@ bench/pressure_temperature_compensation_tb.sv @@
module pressure_temperature_compensation_tb;

  // One compensated reading, as seen on the result channel
  typedef struct {
    ptc_pkg::temp_t  temp_centi;
    ptc_pkg::press_t press;
    ptc_pkg::fine_t  fine;
    logic            div_zero;
  } reading_t;

  // One row of the directed table; typed rows carry their expected reading
  typedef struct {
    ptc_pkg::adc_t adc_temp;
    ptc_pkg::adc_t adc_press;
    bit            typed;
    reading_t      want;
  } row_t;

  localparam longint DIVIDEND_LIM = 64'sd9223372036854775807 / 3125;
  localparam longint QUOT_LIM     = 64'sd68719476736;
  localparam longint PRESS_MAX    = 64'sd4294967295;
  localparam int     DRAIN_CYCLES = 60;   // a little over the 55 pipeline stages
  localparam int     HOLD_CYCLES  = 150;  // long receiver hold-off
  localparam int     IDLE_LIMIT   = 4000; // watchdog: cycles with no transaction

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  ptc_pkg::adc_t   in_adc_temp = '0;
  ptc_pkg::adc_t   in_adc_press = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  ptc_pkg::temp_t  out_temp_centi;
  ptc_pkg::press_t out_press_q24_8;
  ptc_pkg::fine_t  out_fine_temp;
  logic            out_div_zero;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [4:0]      paddr = '0;
  logic [63:0]     pwdata = '0;
  logic [63:0]     prdata;
  logic            pready;

  ptc_pkg::calib_t cal_shadow = '0;   // calibration as the block should hold it
  reading_t        pending_readings[$];
  int              fail_count = 0;
  bit              no_idle = 1'b0;    // stretch where neither side idles
  bit              hold_req = 1'b0;   // asks the receiver for a long hold-off
  int              idle_cycles = 0;

  pressure_temperature_compensation DUT (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_adc_temp, .in_adc_press,
    .out_valid, .out_stall, .out_temp_centi, .out_press_q24_8,
    .out_fine_temp, .out_div_zero,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  function automatic longint sat(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Integer compensation; >>> on longint floors, / truncates toward zero
  function automatic reading_t compensate(ptc_pkg::calib_t c, ptc_pkg::adc_t adc_t_raw,
                                          ptc_pkg::adc_t adc_p_raw);
    longint at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint a, b, d, tf, tc, den, ah, al, num, q, pr;
    reading_t r;
    at = longint'(adc_t_raw);
    ap = longint'(adc_p_raw);
    t1 = longint'(c.t1); t2 = longint'(c.t2); t3 = longint'(c.t3);
    p1 = longint'(c.p1); p2 = longint'(c.p2); p3 = longint'(c.p3);
    p4 = longint'(c.p4); p5 = longint'(c.p5); p6 = longint'(c.p6);
    p7 = longint'(c.p7); p8 = longint'(c.p8); p9 = longint'(c.p9);

    // temperature path
    a  = (((at >>> 3) - 2 * t1) * t2) >>> 11;
    d  = (at >>> 4) - t1;
    b  = (((d * d) >>> 12) * t3) >>> 14;
    tf = sat(a + b, -524288, 524287);
    tc = sat((tf * 5 + 128) >>> 8, -4000, 8500);

    // pressure coefficients
    a  = tf - 128000;
    b  = a * a * p6 + a * p5 * 131072 + p4 * (longint'(1) << 35);
    a  = ((a * a * p3) >>> 8) + a * p2 * 4096 + (longint'(1) << 47);
    ah = a >>> 17;
    al = a - ah * 131072;
    den = (ah * p1 + ((al * p1) >>> 17)) >>> 16;

    r.temp_centi = ptc_pkg::temp_t'(tc);
    r.fine       = ptc_pkg::fine_t'(tf);
    if (den == 0) begin
      r.press    = '0;
      r.div_zero = 1'b1;
    end else begin
      num = sat((1048576 - ap) * (longint'(1) << 31) - b, -DIVIDEND_LIM, DIVIDEND_LIM);
      q   = sat((num * 3125) / den, -QUOT_LIM, QUOT_LIM);
      a   = (p9 * (q >>> 13) * (q >>> 13)) >>> 25;
      b   = (p8 * q) >>> 19;
      pr  = sat(((q + a + b) >>> 8) + p7 * 16, 0, PRESS_MAX);
      r.press    = ptc_pkg::press_t'(pr);
      r.div_zero = 1'b0;
    end
    return r;
  endfunction

  // APB write: setup cycle then access cycle, shadow copy updated alongside
  task automatic write_calib(ptc_pkg::reg_idx_t idx, logic [47:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= {16'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ptc_pkg::REG_TEMP_CALIB: {cal_shadow.t1, cal_shadow.t2, cal_shadow.t3} = value;
      ptc_pkg::REG_PRESS_A:    {cal_shadow.p1, cal_shadow.p2, cal_shadow.p3} = value;
      ptc_pkg::REG_PRESS_B:    {cal_shadow.p4, cal_shadow.p5, cal_shadow.p6} = value;
      ptc_pkg::REG_PRESS_C:    {cal_shadow.p7, cal_shadow.p8, cal_shadow.p9} = value;
    endcase
  endtask

  task automatic load_calib(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                            logic [47:0] pc);
    // pipeline must be empty before the calibration moves under it
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_calib(ptc_pkg::REG_TEMP_CALIB, tc);
    write_calib(ptc_pkg::REG_PRESS_A, pa);
    write_calib(ptc_pkg::REG_PRESS_B, pb);
    write_calib(ptc_pkg::REG_PRESS_C, pc);
  endtask

  // Offer one reading; entered and left at a falling edge
  task automatic send_reading(ptc_pkg::adc_t t, ptc_pkg::adc_t p, bit typed,
                              reading_t want);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      in_adc_temp  <= ptc_pkg::adc_t'($urandom);
      in_adc_press <= ptc_pkg::adc_t'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_adc_temp  <= t;
    in_adc_press <= p;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(typed ? want : compensate(cal_shadow, t, p));
    @(negedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic ptc_pkg::adc_t rand_adc();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return ptc_pkg::adc_t'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, a calm stretch, and one long hold-off
  initial begin
    int held;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 27);
      end
    end
  end

  // Result checker: each transaction against the oldest expected reading
  always @(posedge clk) begin
    reading_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("result with nothing expected: temp %0d press %0d", out_temp_centi,
               out_press_q24_8);
        fail_count++;
      end else begin
        w = pending_readings.pop_front();
        if (out_temp_centi !== w.temp_centi) begin
          $error("temp_centi exp %0d got %0d", w.temp_centi, out_temp_centi);
          fail_count++;
        end
        if (out_press_q24_8 !== w.press) begin
          $error("press_q24_8 exp %0d got %0d", w.press, out_press_q24_8);
          fail_count++;
        end
        if (out_fine_temp !== w.fine) begin
          $error("fine_temp exp %0d got %0d", w.fine, out_fine_temp);
          fail_count++;
        end
        if (out_div_zero !== w.div_zero) begin
          $error("div_zero exp %0b got %0b", w.div_zero, out_div_zero);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on stretches with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    reading_t cold;
    reading_t none;
    int i;
    int ph;
    bit typical_loaded;

    // Calibration at reset is all zero: fine and temperature are 0 and the
    // divisor is 0, so every reading comes back with the divide-by-zero flag.
    cold = '{temp_centi: '0, press: '0, fine: '0, div_zero: 1'b1};
    none = '{temp_centi: '0, press: '0, fine: '0, div_zero: 1'b0};
    rows = '{
      '{20'h00000, 20'h00000, 1'b1, cold},
      '{20'hFFFFF, 20'hFFFFF, 1'b1, cold},
      '{20'h00000, 20'hFFFFF, 1'b1, cold},
      '{20'hFFFFF, 20'h00000, 1'b1, cold},
      '{20'h80000, 20'h7FFFF, 1'b1, cold},
      '{20'h55555, 20'hAAAAA, 1'b1, cold},
      // datasheet calibration from here on, checked by the predictor
      '{20'd519888, 20'd415148, 1'b0, none},
      '{20'h00000, 20'h00000, 1'b0, none},
      '{20'hFFFFF, 20'hFFFFF, 1'b0, none},
      '{20'h00000, 20'hFFFFF, 1'b0, none},
      '{20'hFFFFF, 20'h00000, 1'b0, none},
      '{20'h80000, 20'h80000, 1'b0, none},
      '{20'h7FFFF, 20'h7FFFF, 1'b0, none},
      '{20'hAAAAA, 20'h55555, 1'b0, none},
      '{20'd400000, 20'd300000, 1'b0, none},
      '{20'd600000, 20'd500000, 1'b0, none}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    typical_loaded = 1'b0;
    foreach (rows[k]) begin
      if (!rows[k].typed && !typical_loaded) begin
        in_valid <= 1'b0;
        load_calib({16'd27504, 16'd26435, -16'sd1000},
                   {16'd36477, -16'sd10685, 16'sd3024},
                   {16'sd2855, 16'sd140, -16'sd7},
                   {16'sd15500, -16'sd14600, 16'sd6000});
        typical_loaded = 1'b1;
      end
      send_reading(rows[k].adc_temp, rows[k].adc_press, rows[k].typed, rows[k].want);
    end

    // Random phases, each under its own calibration
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ; // keep datasheet values
        1: load_calib({16'hFFFF, 16'h7FFF, 16'h7FFF}, {16'hFFFF, 16'h7FFF, 16'h7FFF},
                      {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        2: load_calib({16'h0000, 16'h8000, 16'h8000}, {16'h0001, 16'h8000, 16'h8000},
                      {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000});
        default: load_calib(rand48(), rand48(), rand48(), rand48());
      endcase
      for (i = 0; i < 100; i++) begin
        if (ph == 0 && i == 10) hold_req = 1'b1;   // fill the pipeline
        no_idle = (ph == 1 && i >= 20 && i < 80);
        send_reading(rand_adc(), rand_adc(), 1'b0, none);
      end
      no_idle = 1'b0;
      in_valid <= 1'b0;
    end

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
